// ----- rtl/memory_card_sector_protocol_core_assert.svh -----
// Assertion macros, clocked on clk, disabled while arst_n is low
`ifndef MEMORY_CARD_SECTOR_PROTOCOL_CORE_ASSERT_SVH
`define MEMORY_CARD_SECTOR_PROTOCOL_CORE_ASSERT_SVH

// general implication property
`define MCSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// stalled item holds its payload
`define MCSP_ASSERT_HOLD(lbl, vld, rdy, data, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

// ----- rtl/mcsp_pkg.sv -----
`default_nettype none
package mcsp_pkg;

	localparam int unsigned SECTOR_COUNT_DEF = 1024;
	localparam int unsigned SECTOR_BYTES_DEF = 128;

	typedef enum logic [1:0] {
		ACT_EXCHANGE  = 2'd0,
		ACT_DESELECT  = 2'd1,
		ACT_RESET     = 2'd2,
		ACT_CLEAR_MOD = 2'd3
	} action_t;

	localparam logic [7:0] BYTE_SELECT = 8'h81;
	localparam logic [7:0] CMD_READ    = 8'h52;
	localparam logic [7:0] CMD_WRITE   = 8'h57;
	localparam logic [7:0] CMD_IDENT   = 8'h53;
	localparam logic [7:0] BYTE_ID1    = 8'h5a;
	localparam logic [7:0] BYTE_ID2    = 8'h5d;
	localparam logic [7:0] BYTE_ACK1   = 8'h5c;
	localparam logic [7:0] BYTE_ACK2   = 8'h5d;
	localparam logic [7:0] BYTE_HIZ    = 8'hff;
	localparam logic [7:0] FLAG_DNR    = 8'h08;
	localparam logic [7:0] FLAG_NONE   = 8'h00;
	localparam logic [7:0] STAT_GOOD   = 8'h47;
	localparam logic [7:0] STAT_BADSUM = 8'h4e;
	localparam logic [7:0] STAT_BADSEC = 8'hff;

	typedef struct packed {
		action_t    action;
		logic [7:0] rx_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       ack;
		logic       modified;
	} rsp_item_t;

endpackage
`default_nettype wire

// ----- rtl/memory_card_sector_protocol_core.sv -----
// Each accepted item is registered, then its result is registered at the output;
// the result is held back while the previous result still waits to be taken.
// A new item is not taken while one is held in the stage-1 register; card memory
// is read through the registered rd_q and written when a data item completes.
// Reset: arst_n idles the sequencer, sets the directory flag and clears the modified
// mark at once, then zeroes all SECTOR_COUNT * SECTOR_BYTES bytes of card memory
// (131072 at defaults), with req_ready low throughout.
`default_nettype none
module memory_card_sector_protocol_core #(
	parameter int unsigned SECTOR_COUNT = mcsp_pkg::SECTOR_COUNT_DEF,
	parameter int unsigned SECTOR_BYTES = mcsp_pkg::SECTOR_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output      logic                req_ready,
	input  wire mcsp_pkg::req_item_t req,
	output      logic                rsp_valid,
	input  wire logic                rsp_ready,
	output      mcsp_pkg::rsp_item_t rsp
);
	import mcsp_pkg::*;

	localparam int unsigned MEM_DEPTH = SECTOR_COUNT * SECTOR_BYTES;
	localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int unsigned IDX_W     = $clog2(SECTOR_BYTES);
	localparam logic [16:0] SC_L      = 17'(SECTOR_COUNT);
	localparam logic [15:0] SC16      = 16'(SECTOR_COUNT);
	localparam logic [15:0] SB16      = 16'(SECTOR_BYTES);
	localparam logic [23:0] SB24      = 24'(SECTOR_BYTES);
	localparam logic [IDX_W:0] SB_IDX = (IDX_W + 1)'(SECTOR_BYTES);
	localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);

	typedef enum logic [29:0] {
		PH_IDLE   = 30'd1 << 0,
		PH_CMD    = 30'd1 << 1,
		PH_R_ID1  = 30'd1 << 2,
		PH_R_ID2  = 30'd1 << 3,
		PH_R_AH   = 30'd1 << 4,
		PH_R_AL   = 30'd1 << 5,
		PH_R_ACK1 = 30'd1 << 6,
		PH_R_ACK2 = 30'd1 << 7,
		PH_R_CH   = 30'd1 << 8,
		PH_R_CL   = 30'd1 << 9,
		PH_R_DATA = 30'd1 << 10,
		PH_R_SUM  = 30'd1 << 11,
		PH_R_END  = 30'd1 << 12,
		PH_W_ID1  = 30'd1 << 13,
		PH_W_ID2  = 30'd1 << 14,
		PH_W_AH   = 30'd1 << 15,
		PH_W_AL   = 30'd1 << 16,
		PH_W_DATA = 30'd1 << 17,
		PH_W_SUM  = 30'd1 << 18,
		PH_W_ACK1 = 30'd1 << 19,
		PH_W_ACK2 = 30'd1 << 20,
		PH_W_END  = 30'd1 << 21,
		PH_S_ID1  = 30'd1 << 22,
		PH_S_ID2  = 30'd1 << 23,
		PH_S_ACK1 = 30'd1 << 24,
		PH_S_ACK2 = 30'd1 << 25,
		PH_S_CNTH = 30'd1 << 26,
		PH_S_CNTL = 30'd1 << 27,
		PH_S_SZH  = 30'd1 << 28,
		PH_S_SZL  = 30'd1 << 29
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             dnr_q, dnr_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [15:0]      sect_q, sect_d;
	logic [7:0]       prev_q, prev_d;
	logic [7:0]       hsum_q, hsum_d;
	logic [7:0]       rxor_q, rxor_d;
	logic             mod_q, mod_d;

	logic             clearing_q;
	logic [MEM_AW-1:0] clr_addr_q;

	logic             v_s1;
	req_item_t        item_s1;

	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic [7:0]       mem [MEM_DEPTH];
	logic [7:0]       rd_q;
	logic [23:0]      pos;
	logic [MEM_AW-1:0] mem_addr;
	logic             mem_we;

	logic             addr_ok;
	logic [IDX_W:0]   idx_inc;
	logic             idx_last;
	logic [IDX_W-1:0] idx_adv;
	logic [7:0]       tx_d;
	logic             ack_d;
	logic [7:0]       rd_byte;
	logic             s1_done;

	assign req_ready = !clearing_q && !v_s1;
	assign s1_done   = v_s1 && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign addr_ok  = {1'b0, sect_q} < SC_L;
	assign pos      = 24'(sect_q) * SB24 + 24'(idx_q);
	assign mem_addr = pos[MEM_AW-1:0];
	assign idx_inc  = {1'b0, idx_q} + (IDX_W + 1)'(1);
	assign idx_last = idx_inc >= SB_IDX;
	assign idx_adv  = idx_last ? '0 : idx_inc[IDX_W-1:0];
	assign rd_byte  = addr_ok ? rd_q : BYTE_HIZ;

	always_comb begin
		phase_d = phase_q;
		dnr_d   = dnr_q;
		idx_d   = idx_q;
		sect_d  = sect_q;
		prev_d  = prev_q;
		hsum_d  = hsum_q;
		rxor_d  = rxor_q;
		mod_d   = mod_q;
		tx_d    = BYTE_HIZ;
		ack_d   = 1'b0;
		mem_we  = 1'b0;
		unique case (item_s1.action)
			ACT_EXCHANGE: begin
				ack_d = 1'b1;
				unique case (phase_q)
					PH_CMD: begin
						tx_d = dnr_q ? FLAG_DNR : FLAG_NONE;
						if (item_s1.rx_byte == CMD_READ) begin
							phase_d = PH_R_ID1;
						end else if (item_s1.rx_byte == CMD_WRITE) begin
							phase_d = PH_W_ID1;
						end else if (item_s1.rx_byte == CMD_IDENT) begin
							phase_d = PH_S_ID1;
						end else begin
							phase_d = PH_IDLE;
							ack_d   = 1'b0;
						end
					end
					PH_R_ID1: begin tx_d = BYTE_ID1; phase_d = PH_R_ID2; end
					PH_W_ID1: begin tx_d = BYTE_ID1; phase_d = PH_W_ID2; end
					PH_S_ID1: begin tx_d = BYTE_ID1; phase_d = PH_S_ID2; end
					PH_R_ID2: begin tx_d = BYTE_ID2; phase_d = PH_R_AH; end
					PH_W_ID2: begin tx_d = BYTE_ID2; phase_d = PH_W_AH; end
					PH_S_ID2: begin tx_d = BYTE_ID2; phase_d = PH_S_ACK1; end
					PH_R_AH, PH_W_AH: begin
						tx_d    = 8'h00;
						prev_d  = item_s1.rx_byte;
						sect_d  = {item_s1.rx_byte, sect_q[7:0]};
						phase_d = (phase_q == PH_R_AH) ? PH_R_AL : PH_W_AL;
					end
					PH_R_AL, PH_W_AL: begin
						tx_d    = prev_q;
						rxor_d  = prev_q ^ item_s1.rx_byte;
						prev_d  = item_s1.rx_byte;
						sect_d  = {sect_q[15:8], item_s1.rx_byte};
						phase_d = (phase_q == PH_R_AL) ? PH_R_ACK1 : PH_W_DATA;
					end
					PH_R_ACK1: begin tx_d = BYTE_ACK1; phase_d = PH_R_ACK2; end
					PH_W_ACK1: begin tx_d = BYTE_ACK1; phase_d = PH_W_ACK2; end
					PH_S_ACK1: begin tx_d = BYTE_ACK1; phase_d = PH_S_ACK2; end
					PH_R_ACK2: begin tx_d = BYTE_ACK2; phase_d = PH_R_CH; end
					PH_W_ACK2: begin tx_d = BYTE_ACK2; phase_d = PH_W_END; end
					PH_S_ACK2: begin tx_d = BYTE_ACK2; phase_d = PH_S_CNTH; end
					PH_R_CH: begin
						tx_d    = addr_ok ? sect_q[15:8] : BYTE_HIZ;
						phase_d = PH_R_CL;
					end
					PH_R_CL: begin
						if (addr_ok) begin
							tx_d    = sect_q[7:0];
							phase_d = PH_R_DATA;
						end else begin
							tx_d    = BYTE_HIZ;
							phase_d = PH_IDLE;
							ack_d   = 1'b0;
						end
					end
					PH_R_DATA: begin
						tx_d   = rd_byte;
						rxor_d = rxor_q ^ rd_byte;
						idx_d  = idx_adv;
						if (idx_last) begin
							phase_d = PH_R_SUM;
						end
					end
					PH_R_SUM: begin tx_d = rxor_q; phase_d = PH_R_END; end
					PH_R_END: begin
						tx_d    = STAT_GOOD;
						phase_d = PH_IDLE;
						ack_d   = 1'b0;
					end
					PH_W_DATA: begin
						tx_d   = prev_q;
						prev_d = item_s1.rx_byte;
						if (idx_q == '0) begin
							dnr_d = 1'b0;
						end
						if (addr_ok) begin
							mem_we = 1'b1;
							if (rd_q != item_s1.rx_byte) begin
								mod_d = 1'b1;
							end
						end
						rxor_d = rxor_q ^ item_s1.rx_byte;
						idx_d  = idx_adv;
						if (idx_last) begin
							phase_d = PH_W_SUM;
						end
					end
					PH_W_SUM: begin
						tx_d    = prev_q;
						hsum_d  = item_s1.rx_byte;
						phase_d = PH_W_ACK1;
					end
					PH_W_END: begin
						if (!addr_ok) begin
							tx_d = STAT_BADSEC;
						end else if (hsum_q != rxor_q) begin
							tx_d = STAT_BADSUM;
						end else begin
							tx_d = STAT_GOOD;
						end
						phase_d = PH_IDLE;
						ack_d   = 1'b0;
					end
					PH_S_CNTH: begin tx_d = SC16[15:8]; phase_d = PH_S_CNTL; end
					PH_S_CNTL: begin tx_d = SC16[7:0];  phase_d = PH_S_SZH; end
					PH_S_SZH:  begin tx_d = SB16[15:8]; phase_d = PH_S_SZL; end
					PH_S_SZL: begin
						tx_d    = SB16[7:0];
						phase_d = PH_IDLE;
						ack_d   = 1'b0;
					end
					default: begin
						tx_d = BYTE_HIZ;
						if (item_s1.rx_byte == BYTE_SELECT) begin
							phase_d = PH_CMD;
						end else begin
							phase_d = PH_IDLE;
							ack_d   = 1'b0;
						end
					end
				endcase
				if (!ack_d) begin
					idx_d  = '0;
					sect_d = '0;
					prev_d = '0;
					hsum_d = '0;
				end
			end
			ACT_DESELECT, ACT_RESET: begin
				phase_d = PH_IDLE;
				idx_d   = '0;
				sect_d  = '0;
				prev_d  = '0;
				hsum_d  = '0;
				if (item_s1.action == ACT_RESET) begin
					dnr_d = 1'b1;
				end
			end
			ACT_CLEAR_MOD: begin
				mod_d = 1'b0;
			end
			default: begin
				mod_d = mod_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dnr_q   <= 1'b1;
			idx_q   <= '0;
			sect_q  <= '0;
			prev_q  <= '0;
			hsum_q  <= '0;
			rxor_q  <= '0;
			mod_q   <= 1'b0;
		end else if (s1_done) begin
			phase_q <= phase_d;
			dnr_q   <= dnr_d;
			idx_q   <= idx_d;
			sect_q  <= sect_d;
			prev_q  <= prev_d;
			hsum_q  <= hsum_d;
			rxor_q  <= rxor_d;
			mod_q   <= mod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + MEM_AW'(1);
			if (clr_addr_q == MEM_LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				v_s1 <= 1'b1;
			end else if (s1_done) begin
				v_s1 <= 1'b0;
			end
			if (s1_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (s1_done) begin
			rsp_q.tx_byte  <= tx_d;
			rsp_q.ack      <= ack_d;
			rsp_q.modified <= mod_d;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= 8'h00;
		end else if (s1_done && mem_we) begin
			mem[mem_addr] <= item_s1.rx_byte;
		end
		rd_q <= mem[mem_addr];
	end

endmodule
`default_nettype wire

// ----- rtl/mcsp_checker.sv -----
`default_nettype none
`include "memory_card_sector_protocol_core_assert.svh"
module mcsp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire mcsp_pkg::req_item_t req,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire mcsp_pkg::rsp_item_t rsp
);
	import mcsp_pkg::*;

	logic req_fire;
	logic rsp_free;

	assign req_fire = req_valid && req_ready;
	assign rsp_free = !rsp_valid || rsp_ready;

	`MCSP_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp, "result changed while stalled")
	`MCSP_ASSERT(a_one_in_flight, req_fire |=> !req_ready, "item taken while one in flight")
	`MCSP_ASSERT(a_latency, (req_fire && rsp_free) |-> ##2 rsp_valid, "result late")
	`MCSP_ASSERT(a_clear_mod, (req_fire && rsp_free && req.action == ACT_CLEAR_MOD) |-> ##2 !rsp.modified, "modified mark not cleared")

endmodule

bind memory_card_sector_protocol_core mcsp_checker u_mcsp_checker (.*);
`default_nettype wire

// ----- test/memory_card_sector_protocol_core_tb.sv -----
`timescale 1ns / 1ps
module memory_card_sector_protocol_core_tb;
	import mcsp_pkg::*;

	localparam int unsigned CARD_BYTES     = SECTOR_COUNT_DEF * SECTOR_BYTES_DEF;
	localparam int          ITEM_TARGET    = 1300;
	localparam int          WATCHDOG_LIMIT = 400000;
	localparam int          DRAIN_CYCLES   = 30;
	localparam int          REPORT_CAP     = 40;

	typedef enum logic [4:0] {
		STG_IDLE, STG_CMD,
		STG_RD_ID1, STG_RD_ID2, STG_RD_ADDR_HI, STG_RD_ADDR_LO, STG_RD_ACK1, STG_RD_ACK2,
		STG_RD_ECHO_HI, STG_RD_ECHO_LO, STG_RD_DATA, STG_RD_SUM, STG_RD_STATUS,
		STG_WR_ID1, STG_WR_ID2, STG_WR_ADDR_HI, STG_WR_ADDR_LO, STG_WR_DATA, STG_WR_SUM,
		STG_WR_ACK1, STG_WR_ACK2, STG_WR_STATUS,
		STG_ID_ID1, STG_ID_ID2, STG_ID_ACK1, STG_ID_ACK2,
		STG_ID_CNT_HI, STG_ID_CNT_LO, STG_ID_SZ_HI, STG_ID_SZ_LO
	} stage_t;

	class card_mirror;
		bit [7:0]  mem [0:CARD_BYTES-1];
		stage_t    stage;
		bit        dir_unread;
		bit [6:0]  idx;
		bit [15:0] sector;
		bit [7:0]  prev;
		bit [7:0]  host_sum;
		bit [7:0]  run_xor;
		bit        modified;
		rsp_item_t replies[$];
		int        errors;
		int        checked;

		function new();
			stage = STG_IDLE;
			dir_unread = 1'b1;
			idx = '0;
			sector = '0;
			prev = '0;
			host_sum = '0;
			run_xor = '0;
			modified = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void end_transfer();
			stage = STG_IDLE;
			idx = '0;
			sector = '0;
			prev = '0;
			host_sum = '0;
		endfunction

		function bit step_index();
			if (idx == 7'(SECTOR_BYTES_DEF - 1)) begin
				idx = '0;
				return 1'b1;
			end
			idx = idx + 7'd1;
			return 1'b0;
		endfunction

		function rsp_item_t predict(req_item_t it);
			rsp_item_t   r;
			bit          in_range;
			int unsigned pos;
			logic [7:0]  b;
			b = it.rx_byte;
			r.tx_byte = BYTE_HIZ;
			r.ack = 1'b0;
			in_range = sector < SECTOR_COUNT_DEF;
			pos = sector * SECTOR_BYTES_DEF + idx;
			case (it.action)
				ACT_EXCHANGE: begin
					r.ack = 1'b1;
					case (stage)
						STG_CMD: begin
							r.tx_byte = dir_unread ? FLAG_DNR : FLAG_NONE;
							if (b == CMD_READ) stage = STG_RD_ID1;
							else if (b == CMD_WRITE) stage = STG_WR_ID1;
							else if (b == CMD_IDENT) stage = STG_ID_ID1;
							else begin
								stage = STG_IDLE;
								r.ack = 1'b0;
							end
						end
						STG_RD_ID1: begin r.tx_byte = BYTE_ID1; stage = STG_RD_ID2; end
						STG_WR_ID1: begin r.tx_byte = BYTE_ID1; stage = STG_WR_ID2; end
						STG_ID_ID1: begin r.tx_byte = BYTE_ID1; stage = STG_ID_ID2; end
						STG_RD_ID2: begin r.tx_byte = BYTE_ID2; stage = STG_RD_ADDR_HI; end
						STG_WR_ID2: begin r.tx_byte = BYTE_ID2; stage = STG_WR_ADDR_HI; end
						STG_ID_ID2: begin r.tx_byte = BYTE_ID2; stage = STG_ID_ACK1; end
						STG_RD_ADDR_HI, STG_WR_ADDR_HI: begin
							r.tx_byte = 8'h00;
							prev = b;
							sector[15:8] = b;
							stage = (stage == STG_RD_ADDR_HI) ? STG_RD_ADDR_LO : STG_WR_ADDR_LO;
						end
						STG_RD_ADDR_LO, STG_WR_ADDR_LO: begin
							r.tx_byte = prev;
							run_xor = prev ^ b;
							prev = b;
							sector[7:0] = b;
							stage = (stage == STG_RD_ADDR_LO) ? STG_RD_ACK1 : STG_WR_DATA;
						end
						STG_RD_ACK1: begin r.tx_byte = BYTE_ACK1; stage = STG_RD_ACK2; end
						STG_WR_ACK1: begin r.tx_byte = BYTE_ACK1; stage = STG_WR_ACK2; end
						STG_ID_ACK1: begin r.tx_byte = BYTE_ACK1; stage = STG_ID_ACK2; end
						STG_RD_ACK2: begin r.tx_byte = BYTE_ACK2; stage = STG_RD_ECHO_HI; end
						STG_WR_ACK2: begin r.tx_byte = BYTE_ACK2; stage = STG_WR_STATUS; end
						STG_ID_ACK2: begin r.tx_byte = BYTE_ACK2; stage = STG_ID_CNT_HI; end
						STG_RD_ECHO_HI: begin
							r.tx_byte = in_range ? sector[15:8] : BYTE_HIZ;
							stage = STG_RD_ECHO_LO;
						end
						STG_RD_ECHO_LO: begin
							if (in_range) begin
								r.tx_byte = sector[7:0];
								stage = STG_RD_DATA;
							end else begin
								stage = STG_IDLE;
								r.ack = 1'b0;
							end
						end
						STG_RD_DATA: begin
							r.tx_byte = in_range ? mem[pos] : BYTE_HIZ;
							run_xor ^= r.tx_byte;
							if (step_index()) stage = STG_RD_SUM;
						end
						STG_RD_SUM: begin r.tx_byte = run_xor; stage = STG_RD_STATUS; end
						STG_RD_STATUS: begin
							r.tx_byte = STAT_GOOD;
							stage = STG_IDLE;
							r.ack = 1'b0;
						end
						STG_WR_DATA: begin
							r.tx_byte = prev;
							prev = b;
							if (idx == 0) dir_unread = 1'b0;
							if (in_range) begin
								if (mem[pos] != b) modified = 1'b1;
								mem[pos] = b;
							end
							run_xor ^= b;
							if (step_index()) stage = STG_WR_SUM;
						end
						STG_WR_SUM: begin
							r.tx_byte = prev;
							host_sum = b;
							stage = STG_WR_ACK1;
						end
						STG_WR_STATUS: begin
							if (!in_range) r.tx_byte = STAT_BADSEC;
							else if (host_sum != run_xor) r.tx_byte = STAT_BADSUM;
							else r.tx_byte = STAT_GOOD;
							stage = STG_IDLE;
							r.ack = 1'b0;
						end
						STG_ID_CNT_HI: begin
							r.tx_byte = 8'((SECTOR_COUNT_DEF >> 8) & 8'hff);
							stage = STG_ID_CNT_LO;
						end
						STG_ID_CNT_LO: begin
							r.tx_byte = 8'(SECTOR_COUNT_DEF & 8'hff);
							stage = STG_ID_SZ_HI;
						end
						STG_ID_SZ_HI: begin
							r.tx_byte = 8'((SECTOR_BYTES_DEF >> 8) & 8'hff);
							stage = STG_ID_SZ_LO;
						end
						STG_ID_SZ_LO: begin
							r.tx_byte = 8'(SECTOR_BYTES_DEF & 8'hff);
							stage = STG_IDLE;
							r.ack = 1'b0;
						end
						default: begin
							if (b == BYTE_SELECT) stage = STG_CMD;
							else begin
								stage = STG_IDLE;
								r.ack = 1'b0;
							end
						end
					endcase
				end
				ACT_DESELECT: end_transfer();
				ACT_RESET: begin
					end_transfer();
					dir_unread = 1'b1;
				end
				default: modified = 1'b0;
			endcase
			r.modified = modified;
			return r;
		endfunction

		function void note(req_item_t it);
			replies.push_back(predict(it));
		endfunction

		task report(string what);
			if (errors < REPORT_CAP) $display("mismatch at result %0d: %s", checked, what);
			errors++;
		endtask

		task check(rsp_item_t got);
			rsp_item_t want;
			checked++;
			if (replies.size() == 0) begin
				report($sformatf("unexpected result tx %02h ack %0b mod %0b",
					got.tx_byte, got.ack, got.modified));
				return;
			end
			want = replies.pop_front();
			if (got.tx_byte !== want.tx_byte)
				report($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
			if (got.ack !== want.ack)
				report($sformatf("ack %0b, expected %0b", got.ack, want.ack));
			if (got.modified !== want.modified)
				report($sformatf("modified %0b, expected %0b", got.modified, want.modified));
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	card_mirror  mirror;
	logic [7:0]  frame[$];
	logic [15:0] written[$];
	bit          req_burst;
	bit          rsp_burst;
	int          sent;
	int          idle_cycles;
	int          n_writes;
	int          n_reads;
	int          n_idents;
	int          n_cut;

	memory_card_sector_protocol_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send(action_t act, logic [7:0] b);
		int gap;
		if ($urandom_range(0, 99) < 4) req_burst = !req_burst;
		gap = req_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: act, rx_byte: b};
		do @(posedge clk); while (req_ready !== 1'b1);
		mirror.note(req);
		sent++;
		@(negedge clk);
	endtask

	task automatic xb(logic [7:0] b);
		send(ACT_EXCHANGE, b);
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_sector();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45 && written.size() > 0) return written[$urandom_range(0, written.size() - 1)];
		if (k < 70) return 16'($urandom_range(0, SECTOR_COUNT_DEF - 1));
		if (k < 76) return 16'd0;
		if (k < 82) return 16'(SECTOR_COUNT_DEF - 1);
		if (k < 87) return 16'(SECTOR_COUNT_DEF);
		if (k < 91) return 16'hffff;
		return 16'($urandom_range(SECTOR_COUNT_DEF, 65535));
	endfunction

	function automatic void frame_write(logic [15:0] sec);
		int         i;
		int         mode;
		int         poke;
		logic [7:0] d;
		logic [7:0] sum;
		mode = (sec < SECTOR_COUNT_DEF) ? $urandom_range(0, 2) : 0;
		poke = $urandom_range(0, SECTOR_BYTES_DEF - 1);
		frame.delete();
		frame.push_back(BYTE_SELECT);
		frame.push_back(CMD_WRITE);
		frame.push_back(rnd_byte());
		frame.push_back(rnd_byte());
		frame.push_back(sec[15:8]);
		frame.push_back(sec[7:0]);
		sum = sec[15:8] ^ sec[7:0];
		for (i = 0; i < SECTOR_BYTES_DEF; i++) begin
			if (mode == 0 || (mode == 2 && i == poke)) d = rnd_byte();
			else d = mirror.mem[sec * SECTOR_BYTES_DEF + i];
			frame.push_back(d);
			sum ^= d;
		end
		if ($urandom_range(0, 3) == 0) sum ^= 8'($urandom_range(1, 255));
		frame.push_back(sum);
		repeat (3) frame.push_back(rnd_byte());
	endfunction

	function automatic void frame_read(logic [15:0] sec);
		frame.delete();
		frame.push_back(BYTE_SELECT);
		frame.push_back(CMD_READ);
		frame.push_back(rnd_byte());
		frame.push_back(rnd_byte());
		frame.push_back(sec[15:8]);
		frame.push_back(sec[7:0]);
		repeat (4) frame.push_back(rnd_byte());
		if (sec < SECTOR_COUNT_DEF) repeat (SECTOR_BYTES_DEF + 2) frame.push_back(rnd_byte());
	endfunction

	function automatic void frame_ident();
		frame.delete();
		frame.push_back(BYTE_SELECT);
		frame.push_back(CMD_IDENT);
		repeat (8) frame.push_back(rnd_byte());
	endfunction

	task automatic play_frame(int cut);
		int i;
		for (i = 0; i < cut; i++) xb(frame[i]);
		if (cut < frame.size()) begin
			n_cut++;
			case ($urandom_range(0, 2))
				0: send(ACT_DESELECT, rnd_byte());
				1: send(ACT_RESET, rnd_byte());
				default: ;
			endcase
		end
	endtask

	initial begin
		int          rsp_stall;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 99) < 4) rsp_burst = !rsp_burst;
			rsp_stall = rsp_burst ? 0 : $urandom_range(0, 11);
			if (rsp_stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			mirror.check(rsp);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cycles);
			$display("memory_card_sector_protocol_core_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int          k;
		int          kind;
		int          cut;
		logic [15:0] sec;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		idle_cycles = 0;
		mirror = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		xb(BYTE_HIZ);
		xb(BYTE_SELECT);
		xb(8'h00);
		xb(BYTE_SELECT);
		xb(CMD_IDENT);
		repeat (4) begin
			xb(8'h00);
			xb(8'hff);
		end
		xb(BYTE_SELECT);
		xb(CMD_READ);
		send(ACT_DESELECT, 8'hff);
		xb(BYTE_SELECT);
		send(ACT_RESET, 8'h00);
		send(ACT_CLEAR_MOD, 8'h5a);
		frame_read(16'hffff);
		play_frame(frame.size());

		while (sent < ITEM_TARGET) begin
			k = $urandom_range(0, 99);
			if (k >= 88) begin
				repeat ($urandom_range(1, 6))
					send(action_t'($urandom_range(0, 3)), rnd_byte());
			end else begin
				kind = $urandom_range(0, 9);
				sec = pick_sector();
				if (kind < 4) begin
					frame_write(sec);
					if (sec < SECTOR_COUNT_DEF) written.push_back(sec);
					n_writes++;
				end else if (kind < 8) begin
					frame_read(sec);
					n_reads++;
				end else begin
					frame_ident();
					n_idents++;
				end
				cut = (k >= 72) ? $urandom_range(1, frame.size() - 1) : frame.size();
				play_frame(cut);
			end
		end
		req_valid <= 1'b0;

		while (mirror.replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d items, %0d results checked; %0d writes, %0d reads, %0d identifies",
			sent, mirror.checked, n_writes, n_reads, n_idents);
		$display("run: %0d transfers cut short, %0d sectors written, %0d mismatches",
			n_cut, written.size(), mirror.errors);
		if (mirror.errors == 0) begin
			$display("memory_card_sector_protocol_core_tb OK");
		end else begin
			$display("memory_card_sector_protocol_core_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mcsp_pkg.sv
rtl/memory_card_sector_protocol_core.sv
rtl/mcsp_checker.sv
test/memory_card_sector_protocol_core_tb.sv
